@@ rtl/msm_pkg.sv @@
// Shared widths, scaling constants and types for the magnetometer scale and magnitude block.
`default_nettype none

package msm_pkg;

    // Word field widths
    localparam int AXIS_W   = 16;
    localparam int STATUS_W = 8;
    localparam int FIELD_W  = 18;
    localparam int MAG_W    = 18;

    // Axis scaling: raw * 10000 / 3750 is raw * 8 / 3
    localparam int UT_PER_GAUSS  = 10000;
    localparam int LSB_PER_GAUSS = 3750;
    localparam int SCALE_NUM     = 8;
    localparam int SCALE_NUM_SH  = 3;
    // Reciprocal of 3: ceil(2^20 / 3), exact for dividends below 2^19
    localparam int SCALE_SHIFT   = 20;
    localparam int RECIP_W       = 19;
    localparam logic [RECIP_W-1:0] SCALE_RECIP = RECIP_W'(((1 << SCALE_SHIFT) + 2) / 3);

    // Lane datapath widths
    localparam int ABS_W  = AXIS_W + 1;                 // magnitude of a raw sample
    localparam int DIVD_W = ABS_W + SCALE_NUM_SH;       // magnitude times 8
    localparam int PROD_W = DIVD_W + RECIP_W;           // reciprocal product
    localparam int QUOT_W = 17;                         // scaled magnitude, max 87381
    localparam int SQ_W   = 2 * QUOT_W;                 // square of scaled magnitude

    // Root unit widths: sum of three squares, one root bit per step
    localparam int RAD_W  = 2 * MAG_W;
    localparam int REM_W  = MAG_W + 1;
    localparam int STEP_W = $clog2(MAG_W);

    // Status bit positions
    localparam int READY_BIT    = 0;
    localparam int OVERFLOW_BIT = 1;

    // Lane-to-merge timing: cycles from capture until the sum register holds
    localparam int FILL_W = 2;
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(3);

    // Root unit status toward the controller
    typedef struct packed {
        logic busy;
        logic done;
    } msm_root_stat_t;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCALE = 3'b010,
        S_ROOT  = 3'b100
    } msm_state_t;

endpackage

`default_nettype wire

@@ rtl/msm_lane.sv @@
// One axis lane: scale a raw sample to microtesla x100 and square its magnitude.
`default_nettype none

module msm_lane (
    input  logic                                clk,
    input  logic signed [msm_pkg::AXIS_W-1:0]   raw,
    output logic signed [msm_pkg::FIELD_W-1:0]  field,
    output logic        [msm_pkg::SQ_W-1:0]     square
);
    import msm_pkg::*;

    logic [ABS_W-1:0]          raw_ext;
    logic [ABS_W-1:0]          mag_abs;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic                      neg_reg;
    logic [QUOT_W-1:0]         quot;
    logic signed [FIELD_W-1:0] field_reg, field_next;
    logic [SQ_W-1:0]           square_reg, square_next;

    // Take the magnitude and multiply 8*|raw| by the reciprocal of 3
    always_comb
    begin
        raw_ext   = {raw[AXIS_W-1], raw};
        mag_abs   = raw[AXIS_W-1] ? (~raw_ext + ABS_W'(1)) : raw_ext;
        prod_next = PROD_W'({mag_abs, {SCALE_NUM_SH{1'b0}}}) * PROD_W'(SCALE_RECIP);
    end

    // Drop the fraction, restore the sign, square the magnitude
    always_comb
    begin
        quot        = prod_reg[SCALE_SHIFT +: QUOT_W];
        field_next  = neg_reg ? (FIELD_W'(0) - FIELD_W'(quot)) : FIELD_W'(quot);
        square_next = SQ_W'(quot) * SQ_W'(quot);
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        neg_reg    <= raw[AXIS_W-1];
        field_reg  <= field_next;
        square_reg <= square_next;
    end

    assign field  = field_reg;
    assign square = square_reg;

endmodule

`default_nettype wire

@@ rtl/msm_root.sv @@
// Iterative floor square root, one result bit per cycle.
`default_nettype none

module msm_root (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [msm_pkg::RAD_W-1:0]     radicand,
    output logic [msm_pkg::MAG_W-1:0]     root,
    output msm_pkg::msm_root_stat_t       stat
);
    import msm_pkg::*;

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              fit;

    // Bring down two radicand bits and try the next root bit
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        fit    = (rem_sh >= trial);
    end

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = fit ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_next = {root_reg[MAG_W-2:0], fit};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    // A new root starts only when the unit is free
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("root start while busy");

    // Done follows the last step of a running root
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("root done without a running root");

    // Busy and done never overlap
    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("root busy and done together");

endmodule

`default_nettype wire

@@ rtl/magnetometer_scale_and_magnitude.sv @@
// Top level: three axis lanes, sum of squares merge, root unit and result register.
`default_nettype none

// One sample is taken when start is high and busy is low. The result appears
// on the output ports with done high for exactly one cycle, and is not held
// back by the receiver; the outputs keep their values until the next result.
// Busy drops in the cycle done is shown, so a new sample can be taken at the
// next edge, but not while a sample is in flight. A sample fills the lane
// product and output registers and the sum register in turn, loads the root
// unit, runs the bit-per-cycle square root over the 36-bit sum of squares and
// then has its result registered together with the strobe.
module magnetometer_scale_and_magnitude (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [msm_pkg::AXIS_W-1:0]   axis_x,
    input  logic signed [msm_pkg::AXIS_W-1:0]   axis_y,
    input  logic signed [msm_pkg::AXIS_W-1:0]   axis_z,
    input  logic        [msm_pkg::STATUS_W-1:0] status_byte,
    output logic                                done,
    output logic signed [msm_pkg::FIELD_W-1:0]  field_x,
    output logic signed [msm_pkg::FIELD_W-1:0]  field_y,
    output logic signed [msm_pkg::FIELD_W-1:0]  field_z,
    output logic        [msm_pkg::MAG_W-1:0]    magnitude,
    output logic                                ready_flag,
    output logic                                overflow_flag
);
    import msm_pkg::*;

    msm_state_t                state_reg, state_next;
    logic [FILL_W-1:0]         fill_reg, fill_next;
    logic                      done_reg, done_next;
    logic                      accept;
    logic                      root_start;

    logic signed [AXIS_W-1:0]  raw_x_reg, raw_y_reg, raw_z_reg;
    logic                      ready_reg, overflow_reg;

    logic signed [FIELD_W-1:0] lane_fx, lane_fy, lane_fz;
    logic [SQ_W-1:0]           lane_sx, lane_sy, lane_sz;
    logic [RAD_W-1:0]          sum_reg, sum_next;
    logic [MAG_W-1:0]          root_val;
    msm_root_stat_t            root_stat;

    logic signed [FIELD_W-1:0] fx_reg, fy_reg, fz_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      ready_out_reg, overflow_out_reg;

    assign accept = start && (state_reg == S_IDLE);

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_x_reg    <= axis_x;
            raw_y_reg    <= axis_y;
            raw_z_reg    <= axis_z;
            ready_reg    <= status_byte[READY_BIT];
            overflow_reg <= status_byte[OVERFLOW_BIT];
        end
    end

    // Axis lanes
    msm_lane u_lane_x (.clk(clk), .raw(raw_x_reg), .field(lane_fx), .square(lane_sx));
    msm_lane u_lane_y (.clk(clk), .raw(raw_y_reg), .field(lane_fy), .square(lane_sy));
    msm_lane u_lane_z (.clk(clk), .raw(raw_z_reg), .field(lane_fz), .square(lane_sz));

    // Merge: add the three squares at full width
    assign sum_next = RAD_W'(lane_sx) + RAD_W'(lane_sy) + RAD_W'(lane_sz);

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    msm_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sum_reg),
        .root     (root_val),
        .stat     (root_stat)
    );

    // Sequence one sample through the lanes and the root unit
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        done_next  = 1'b0;
        root_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCALE;
                    fill_next  = '0;
                end
            end
            S_SCALE:
            begin
                if (fill_reg == FILL_LAST)
                begin
                    root_start = 1'b1;
                    state_next = S_ROOT;
                end
                else
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            S_ROOT:
            begin
                if (root_stat.done)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    // Hold the result word for the strobe and after it
    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            fx_reg           <= lane_fx;
            fy_reg           <= lane_fy;
            fz_reg           <= lane_fz;
            mag_reg          <= root_val;
            ready_out_reg    <= ready_reg;
            overflow_out_reg <= overflow_reg;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign field_x       = fx_reg;
    assign field_y       = fy_reg;
    assign field_z       = fz_reg;
    assign magnitude     = mag_reg;
    assign ready_flag    = ready_out_reg;
    assign overflow_flag = overflow_out_reg;

    // An accepted word always leads into the lane fill
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SCALE) && (fill_reg == '0))
        else $error("accepted word did not start the lanes");

    // The strobe only follows a finished root
    a_done_from_root: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(root_stat.done) && $past(state_reg == S_ROOT))
        else $error("result strobe without a finished root");

    // The root unit reports done only while the controller waits for it
    a_root_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        root_stat.done |-> (state_reg == S_ROOT))
        else $error("root done outside the root phase");

    // The root unit is busy throughout the root phase until it finishes
    a_root_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT) |-> (root_stat.busy || root_stat.done))
        else $error("root unit idle during the root phase");

endmodule

`default_nettype wire
